>>> hdl/mbe_pkg.sv
// Shared types, constants and the saturation helper for the escape-time pixel unit.
// Depends on nothing; every other file of the block imports it.
package mbe_pkg;

    localparam int FRAC_BITS      = 28;
    localparam int WORD_BITS      = FRAC_BITS + 4;
    localparam int DWORD_BITS     = 2 * WORD_BITS;
    localparam int PIXEL_BITS_DEF = 12;
    localparam int ITER_BITS_DEF  = 16;
    localparam int COLOR_BITS     = 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int LIMIT_REG_BITS = 16;

    typedef logic signed [WORD_BITS-1:0]  t_word;
    typedef logic signed [DWORD_BITS-1:0] t_dword;

    localparam t_word WORD_MAX     = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word WORD_MIN     = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam t_word ESCAPE_BOUND = t_word'(64'sd4 <<< FRAC_BITS);

    localparam t_word X_ORIGIN_RST = t_word'(-64'sd536870912);
    localparam t_word Y_ORIGIN_RST = t_word'(-64'sd268435456);
    localparam t_word X_STEP_RST   = t_word'(64'sd262144);
    localparam t_word Y_STEP_RST   = t_word'(64'sd262144);
    localparam logic [LIMIT_REG_BITS-1:0] ITER_LIMIT_RST = LIMIT_REG_BITS'(255);
    localparam logic [COLOR_BITS-1:0]     COLOR_SCALE_RST = COLOR_BITS'(255);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_X_ORIGIN,
        CFG_Y_ORIGIN,
        CFG_X_STEP,
        CFG_Y_STEP,
        CFG_ITER_LIMIT,
        CFG_COLOR_SCALE
    } t_cfg_index;

    function automatic t_word sat_word(input t_dword v);
        t_word res;
        if ((&v[DWORD_BITS-1:WORD_BITS-1]) || !(|v[DWORD_BITS-1:WORD_BITS-1])) begin
            res = v[WORD_BITS-1:0];
        end else if (v[DWORD_BITS-1]) begin
            res = WORD_MIN;
        end else begin
            res = WORD_MAX;
        end
        return res;
    endfunction

endpackage

>>> hdl/mandelbrot_escape_time_pixel_unit.sv
// Top level of the escape-time pixel unit: configuration registers, point mapping,
// orbit engine and a row of division cells that scales the count to a colour.
// Depends on mbe_pkg, mbe_orbit and mbe_div_cell.
//
// Usage: write the six configuration registers through i_cfg_index and i_cfg_data
// with i_cfg_valid; o_cfg_ready is always high. A pixel transaction is taken at a
// rising edge with start high and busy low, carrying i_px and i_py. busy stays high
// until the colour has been delivered. The result appears on o_color for exactly one
// cycle with o_color_valid high; the receiver cannot stall it.
// Mapping the pixel to a point takes the S_MAP and S_SUM states, and r_orbit_start then
// launches the orbit engine. Each iteration takes a multiply state and an add state, and
// the escape test costs one more such pair. A handover register, eight division cells
// and the output register follow. One pixel is in flight at a time, and the next may be
// accepted at the edge that takes the colour.
// Synchronous active-low reset returns the configuration registers to their mbe_pkg reset
// values, clears the valid flags and leaves the unit idle.
module mandelbrot_escape_time_pixel_unit
    import mbe_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    parameter int ITER_BITS  = ITER_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [PIXEL_BITS-1:0]     i_px,
    input  logic [PIXEL_BITS-1:0]     i_py,
    output logic [COLOR_BITS-1:0]     o_color,
    output logic                      o_color_valid,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int REM_BITS = ITER_BITS + COLOR_BITS;

    typedef enum logic [2:0] {S_IDLE, S_MAP, S_SUM, S_RUN, S_DIV} t_state;

    t_state                r_state;
    t_word                 r_x_origin;
    t_word                 r_y_origin;
    t_word                 r_x_step;
    t_word                 r_y_step;
    logic [ITER_BITS-1:0]  r_limit;
    logic [COLOR_BITS-1:0] r_scale;
    logic [PIXEL_BITS-1:0] r_px;
    logic [PIXEL_BITS-1:0] r_py;
    t_word                 r_mx;
    t_word                 r_my;
    t_word                 r_cx;
    t_word                 r_cy;
    logic                  r_orbit_start;
    logic                  r_div_valid;
    logic                  r_zero;
    logic [REM_BITS-1:0]   r_rem;
    logic [COLOR_BITS-1:0] r_color;
    logic                  r_color_valid;

    logic                  orbit_done;
    logic [ITER_BITS-1:0]  orbit_count;

    logic signed [WORD_BITS+PIXEL_BITS:0] map_x;
    logic signed [WORD_BITS+PIXEL_BITS:0] map_y;

    logic                  chain_valid [0:COLOR_BITS];
    logic                  chain_zero  [0:COLOR_BITS];
    logic [REM_BITS-1:0]   chain_rem   [0:COLOR_BITS];
    logic [COLOR_BITS-1:0] chain_quo   [0:COLOR_BITS];

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_state != S_IDLE);

    assign map_x = $signed({1'b0, r_px}) * r_x_step;
    assign map_y = $signed({1'b0, r_py}) * r_y_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_origin <= X_ORIGIN_RST;
            r_y_origin <= Y_ORIGIN_RST;
            r_x_step   <= X_STEP_RST;
            r_y_step   <= Y_STEP_RST;
            r_limit    <= ITER_BITS'(ITER_LIMIT_RST);
            r_scale    <= COLOR_SCALE_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_X_ORIGIN:    r_x_origin <= i_cfg_data[WORD_BITS-1:0];
                CFG_Y_ORIGIN:    r_y_origin <= i_cfg_data[WORD_BITS-1:0];
                CFG_X_STEP:      r_x_step   <= i_cfg_data[WORD_BITS-1:0];
                CFG_Y_STEP:      r_y_step   <= i_cfg_data[WORD_BITS-1:0];
                CFG_ITER_LIMIT:  r_limit    <= ITER_BITS'(i_cfg_data[LIMIT_REG_BITS-1:0]);
                CFG_COLOR_SCALE: r_scale    <= i_cfg_data[COLOR_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_orbit_start <= 1'b0;
            r_div_valid   <= 1'b0;
            r_color_valid <= 1'b0;
        end else begin
            r_orbit_start <= 1'b0;
            r_div_valid   <= 1'b0;
            r_color_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_px    <= i_px;
                        r_py    <= i_py;
                        r_state <= S_MAP;
                    end
                end
                S_MAP: begin
                    r_mx    <= sat_word(t_dword'(map_x));
                    r_my    <= sat_word(t_dword'(map_y));
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_cx          <= sat_word(t_dword'(r_x_origin) + t_dword'(r_mx));
                    r_cy          <= sat_word(t_dword'(r_y_origin) + t_dword'(r_my));
                    r_orbit_start <= 1'b1;
                    r_state       <= S_RUN;
                end
                S_RUN: begin
                    if (orbit_done) begin
                        r_rem       <= REM_BITS'(r_scale) * REM_BITS'(orbit_count);
                        r_zero      <= (r_limit == '0);
                        r_div_valid <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (chain_valid[COLOR_BITS]) begin
                        r_color       <= chain_zero[COLOR_BITS] ? '0 : chain_quo[COLOR_BITS];
                        r_color_valid <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    mbe_orbit #(
        .ITER_BITS(ITER_BITS)
    ) u_orbit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_orbit_start),
        .i_cx   (r_cx),
        .i_cy   (r_cy),
        .i_limit(r_limit),
        .o_done (orbit_done),
        .o_count(orbit_count)
    );

    assign chain_valid[0] = r_div_valid;
    assign chain_zero[0]  = r_zero;
    assign chain_rem[0]   = r_rem;
    assign chain_quo[0]   = '0;

    for (genvar k = 0; k < COLOR_BITS; k++) begin : g_div
        mbe_div_cell #(
            .DIV_BITS(ITER_BITS),
            .BIT     (COLOR_BITS - 1 - k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(chain_valid[k]),
            .i_zero (chain_zero[k]),
            .i_rem  (chain_rem[k]),
            .i_div  (r_limit),
            .i_quo  (chain_quo[k]),
            .o_valid(chain_valid[k+1]),
            .o_zero (chain_zero[k+1]),
            .o_rem  (chain_rem[k+1]),
            .o_quo  (chain_quo[k+1])
        );
    end

    assign o_color       = r_color;
    assign o_color_valid = r_color_valid;

endmodule

>>> hdl/mbe_div_cell.sv
// One restoring division cell: settles one quotient bit and hands the remainder on.
// Depends on mbe_pkg.
module mbe_div_cell
    import mbe_pkg::*;
#(
    parameter int DIV_BITS = ITER_BITS_DEF,
    parameter int BIT      = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           i_zero,
    input  logic [DIV_BITS+COLOR_BITS-1:0] i_rem,
    input  logic [DIV_BITS-1:0]            i_div,
    input  logic [COLOR_BITS-1:0]          i_quo,
    output logic                           o_valid,
    output logic                           o_zero,
    output logic [DIV_BITS+COLOR_BITS-1:0] o_rem,
    output logic [COLOR_BITS-1:0]          o_quo
);

    localparam int REM_BITS = DIV_BITS + COLOR_BITS;

    logic [REM_BITS-1:0] trial;
    logic                r_valid;
    logic                r_zero;
    logic [REM_BITS-1:0] r_rem;
    logic [COLOR_BITS-1:0] r_quo;

    assign trial = REM_BITS'(i_div) << BIT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_zero <= i_zero;
        if (i_rem >= trial) begin
            r_rem <= i_rem - trial;
            r_quo <= i_quo | (COLOR_BITS'(1) << BIT);
        end else begin
            r_rem <= i_rem;
            r_quo <= i_quo;
        end
    end

    assign o_valid = r_valid;
    assign o_zero  = r_zero;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;

endmodule

>>> hdl/mbe_orbit.sv
// Orbit engine: iterates z = z*z + c in saturating fixed point and counts the steps.
// Depends on mbe_pkg.
module mbe_orbit
    import mbe_pkg::*;
#(
    parameter int ITER_BITS = ITER_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_word                i_cx,
    input  t_word                i_cy,
    input  logic [ITER_BITS-1:0] i_limit,
    output logic                 o_done,
    output logic [ITER_BITS-1:0] o_count
);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_ADD} t_state;

    t_state                r_state;
    t_word                 r_x;
    t_word                 r_y;
    t_dword                r_xx;
    t_dword                r_yy;
    t_dword                r_xy;
    logic [ITER_BITS-1:0]  r_count;
    logic                  r_done;

    t_word                 x2;
    t_word                 y2;
    t_word                 xy2;
    logic [WORD_BITS:0]    mag;
    logic                  escape;
    t_word                 new_x;
    t_word                 new_y;
    logic [ITER_BITS-1:0]  count_inc;

    always_comb begin
        x2        = sat_word(r_xx >>> FRAC_BITS);
        y2        = sat_word(r_yy >>> FRAC_BITS);
        xy2       = sat_word(r_xy >>> (FRAC_BITS - 1));
        mag       = {1'b0, x2} + {1'b0, y2};
        escape    = mag >= (WORD_BITS+1)'(ESCAPE_BOUND);
        new_x     = sat_word(t_dword'(x2) - t_dword'(y2) + t_dword'(i_cx));
        new_y     = sat_word(t_dword'(xy2) + t_dword'(i_cy));
        count_inc = r_count + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_x     <= '0;
                        r_y     <= '0;
                        r_count <= '0;
                        if (i_limit == '0) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_xx    <= r_x * r_x;
                    r_yy    <= r_y * r_y;
                    r_xy    <= r_x * r_y;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (escape) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_x     <= new_x;
                        r_y     <= new_y;
                        r_count <= count_inc;
                        if (count_inc == i_limit) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_count = r_count;

endmodule

>>> tb/mandelbrot_escape_time_pixel_unit_tb.sv
// Self-checking testbench for the escape-time pixel unit: directed and random pixel
// transactions, checked against an in-bench fixed-point orbit predictor.
// Depends on mbe_pkg and mandelbrot_escape_time_pixel_unit.
module mandelbrot_escape_time_pixel_unit_tb;
    import mbe_pkg::*;

    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [11:0]               i_px = '0;
    logic [11:0]               i_py = '0;
    logic [COLOR_BITS-1:0]     o_color;
    logic                      o_color_valid;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data = '0;

    logic [31:0] x_origin_r, y_origin_r, x_step_r, y_step_r;
    logic [15:0] iter_limit_r;
    logic [7:0]  colour_scale_r;

    logic [7:0] expected_colours[$];
    int         mismatches = 0;
    int         idle_pct = 0;

    mandelbrot_escape_time_pixel_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_px(i_px), .i_py(i_py), .o_color(o_color), .o_color_valid(o_color_valid),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint clamp_word(input longint v);
        if (v > WMAX) return WMAX;
        if (v < WMIN) return WMIN;
        return v;
    endfunction

    function automatic longint scaled_product(input longint a, input longint b, input int sh);
        return clamp_word((a * b) >>> sh);
    endfunction

    function automatic logic [7:0] escape_colour(input logic [11:0] px, input logic [11:0] py);
        longint cx, cy, x, y, x2, y2, xy2, bound;
        longint unsigned count, lim;
        bound = 64'sd4 <<< FRAC_BITS;
        lim = iter_limit_r;
        cx = clamp_word(longint'($signed(x_origin_r))
                        + clamp_word(longint'(px) * longint'($signed(x_step_r))));
        cy = clamp_word(longint'($signed(y_origin_r))
                        + clamp_word(longint'(py) * longint'($signed(y_step_r))));
        x = 0;
        y = 0;
        count = 0;
        while (count < lim) begin
            x2 = scaled_product(x, x, FRAC_BITS);
            y2 = scaled_product(y, y, FRAC_BITS);
            if (clamp_word(x2 + y2) >= bound) break;
            xy2 = scaled_product(x, y, FRAC_BITS - 1);
            x = clamp_word(clamp_word(x2 - y2) + cx);
            y = clamp_word(xy2 + cy);
            count++;
        end
        if (lim == 0) return 8'd0;
        return 8'((longint'(colour_scale_r) * count) / lim);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_color_valid) begin
            if (expected_colours.size() == 0) begin
                report_mismatch($sformatf("colour %0d with no pixel outstanding", o_color));
            end else begin
                if (o_color !== expected_colours[0]) begin
                    report_mismatch($sformatf("colour %0d, expected %0d",
                                              o_color, expected_colours[0]));
                end
                void'(expected_colours.pop_front());
            end
        end
    end

    task automatic send_pixel(input logic [11:0] px, input logic [11:0] py);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_px  <= px;
        i_py  <= py;
        do @(posedge i_clk); while (busy);
        expected_colours.push_back(escape_colour(px, py));
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_colours.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_X_ORIGIN:    x_origin_r = data;
            CFG_Y_ORIGIN:    y_origin_r = data;
            CFG_X_STEP:      x_step_r = data;
            CFG_Y_STEP:      y_step_r = data;
            CFG_ITER_LIMIT:  iter_limit_r = data[15:0];
            CFG_COLOR_SCALE: colour_scale_r = data[7:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_view(input logic [31:0] xo, input logic [31:0] yo, input logic [31:0] xs,
                            input logic [31:0] ys, input logic [15:0] lim,
                            input logic [7:0] scale);
        wait_idle();
        write_reg(CFG_X_ORIGIN, xo);
        write_reg(CFG_Y_ORIGIN, yo);
        write_reg(CFG_X_STEP, xs);
        write_reg(CFG_Y_STEP, ys);
        write_reg(CFG_ITER_LIMIT, {16'h0, lim});
        write_reg(CFG_COLOR_SCALE, {24'h0, scale});
    endtask

    task automatic test_reset_view();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd1024, 12'd1024);
        send_pixel(12'd2048, 12'd1000);
    endtask

    task automatic test_limit_extremes();
        set_view(32'h0, 32'h0, 32'h0, 32'h0, 16'd0, 8'd255);
        send_pixel(12'd5, 12'd7);
        set_view(32'h0, 32'h0, 32'h0, 32'h0, 16'd1, 8'd0);
        send_pixel(12'd0, 12'd0);
        set_view(32'h0, 32'h0, 32'h0, 32'h0, 16'd1, 8'd255);
        send_pixel(12'd0, 12'd0);
        set_view(32'h0, 32'h0, 32'd65536, 32'h0, 16'd65535, 8'd255);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd3000, 12'd4095);
    endtask

    task automatic test_saturation();
        set_view(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'd20, 8'd255);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        set_view(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'd20, 8'd200);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd1, 12'd0);
        set_view(32'hE0000000, 32'h00000000, 32'h0, 32'h0, 16'd300, 8'd255);
        send_pixel(12'd4095, 12'd0);
        set_view(32'hC8000000, 32'h00000000, 32'h0, 32'h0, 16'd40, 8'd77);
        send_pixel(12'd0, 12'd0);
    endtask

    task automatic random_view();
        logic [31:0] xo, yo, xs, ys;
        logic [15:0] lim;
        xo = 32'($urandom_range(0, 3 << 28)) - 32'(5 << 27);
        yo = 32'($urandom_range(0, 3 << 28)) - 32'(3 << 27);
        xs = 32'($urandom_range(0, 400000));
        ys = 32'($urandom_range(0, 400000));
        if ($urandom_range(3) == 0) xs = -xs;
        if ($urandom_range(3) == 0) ys = -ys;
        if ($urandom_range(7) == 0) begin
            xo = $urandom;
            yo = $urandom;
            xs = $urandom;
            ys = $urandom;
        end
        lim = ($urandom_range(9) == 0) ? 16'($urandom_range(49, 300))
                                       : 16'($urandom_range(1, 48));
        set_view(xo, yo, xs, ys, lim, 8'($urandom_range(255)));
    endtask

    task automatic test_random(input int count, input int pct);
        wait_idle();
        idle_pct = pct;
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 0) random_view();
            if ($urandom_range(9) == 0) idle_pct = 0;
            else idle_pct = pct;
            send_pixel(12'($urandom), 12'($urandom));
        end
    endtask

    initial begin
        x_origin_r     = X_ORIGIN_RST;
        y_origin_r     = Y_ORIGIN_RST;
        x_step_r       = X_STEP_RST;
        y_step_r       = Y_STEP_RST;
        iter_limit_r   = ITER_LIMIT_RST;
        colour_scale_r = COLOR_SCALE_RST;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_view();
        test_limit_extremes();
        test_saturation();
        test_random(420, 0);
        test_random(410, 50);
        test_random(400, 0);
        test_random(410, 22);
        wait_idle();
        repeat (40) @(posedge i_clk);
        if (expected_colours.size() != 0) begin
            report_mismatch($sformatf("%0d colours never delivered", expected_colours.size()));
        end
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #60000000;
        $display("TIMEOUT with %0d colours outstanding", expected_colours.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
